// ===== design/etpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etpq_pkg
// Shared types, codes and default sizes for the event time priority queue.
// ----------------------------------------------------------------------------
package etpq_pkg;

  localparam int unsigned DefQueueDepth = 16;
  localparam int unsigned DefTimeBits   = 32;
  localparam int unsigned DefTypeBits   = 4;
  localparam int unsigned DefTagBits    = 8;

  localparam int unsigned KindBits   = 2;
  localparam int unsigned StatusBits = 2;

  typedef enum logic [KindBits-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_POP    = 2'd2,
    KIND_NOP    = 2'd3
  } kind_e;

  typedef enum logic [StatusBits-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_INS_WR,
    S_RESP
  } state_e;

  // result of the shared compare unit
  typedef struct packed {
    logic time_le;  // stored time <= key time
    logic type_eq;  // stored type == key type
  } cmp_res_t;

endpackage

// ===== design/etpq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etpq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module etpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/etpq_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etpq_cmp
// Shared compare unit: checks one stored entry against the request key.
// ----------------------------------------------------------------------------
module etpq_cmp #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned TYPE_BITS = 4
) (
  input  logic [TIME_BITS-1:0] slot_time_i,
  input  logic [TYPE_BITS-1:0] slot_type_i,
  input  logic [TIME_BITS-1:0] key_time_i,
  input  logic [TYPE_BITS-1:0] key_type_i,
  output etpq_pkg::cmp_res_t   res_o
);

  import etpq_pkg::*;

  always_comb begin
    res_o         = '0;
    res_o.time_le = (slot_time_i <= key_time_i);
    res_o.type_eq = (slot_type_i == key_type_i);
  end

endmodule

// ===== design/event_time_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_time_priority_queue
// Time-ordered event queue with insert, remove-by-type and pop.
// ----------------------------------------------------------------------------
// Entries sit in one RAM in time order, head at address 0. Each request item
// is handled by a small sequencer around a single RAM port pair and one
// shared compare unit, one request at a time; s_axis_tready is high only
// while idle. An insert scans from the head, a read state and a compare state
// per entry, until it meets a later time, then moves the tail up one slot, a
// read state and a write state per entry, and writes the new entry (no move
// when it lands behind every entry). Remove and pop scan for the target the
// same way and close the gap with a read state and a write state per moved
// entry (pop finds its target at once). Every item then shows its result in
// the result state and passes through idle before the next request is taken.
// Refused requests and the unused kind go straight to the result state; the
// longest item is an insert into a queue holding QUEUE_DEPTH-1 entries. The
// RAM's registered read is why each step has its own read state. The result
// item waits in an output register until m_axis_tready takes it. Ties in
// time keep arrival order. A pop sets the simulation clock to the popped
// time.
// ----------------------------------------------------------------------------
module event_time_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = etpq_pkg::DefQueueDepth,
  parameter int unsigned TIME_BITS   = etpq_pkg::DefTimeBits,
  parameter int unsigned TYPE_BITS   = etpq_pkg::DefTypeBits,
  parameter int unsigned TAG_BITS    = etpq_pkg::DefTagBits,
  // derived sizes, not meant to be overridden
  parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1),
  parameter int unsigned IN_W        = TIME_BITS + TYPE_BITS + TAG_BITS,
  parameter int unsigned IN_DW       = ((IN_W + 7) / 8) * 8,
  parameter int unsigned OUT_W       = 2 * TIME_BITS + TYPE_BITS + TAG_BITS + CNT_W,
  parameter int unsigned OUT_DW      = ((OUT_W + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: expire_time, event_type, event_tag (from bit 0 up), zero padded
  input  logic [IN_DW-1:0]              s_axis_tdata,
  // tuser: kind
  input  logic [etpq_pkg::KindBits-1:0] s_axis_tuser,
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: out_time, out_type, out_tag, now_time, occupancy (from bit 0 up)
  output logic [OUT_DW-1:0]             m_axis_tdata,
  // tuser: status
  output logic [etpq_pkg::StatusBits-1:0] m_axis_tuser
);

  import etpq_pkg::*;

  localparam int unsigned ADDR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned ENTRY_W = TIME_BITS + TYPE_BITS + TAG_BITS;

  // sequencer and request registers
  state_e               state_q, state_d;
  kind_e                kind_q, kind_d;
  logic [TIME_BITS-1:0] key_time_q, key_time_d;
  logic [TYPE_BITS-1:0] key_type_q, key_type_d;
  logic [TAG_BITS-1:0]  key_tag_q, key_tag_d;
  logic [ADDR_W-1:0]    idx_q, idx_d;   // scan index, then move index
  logic [ADDR_W-1:0]    pos_q, pos_d;   // insert position
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [TIME_BITS-1:0] now_q, now_d;

  // result register
  status_e              status_q, status_d;
  logic [TIME_BITS-1:0] res_time_q, res_time_d;
  logic [TYPE_BITS-1:0] res_type_q, res_type_d;
  logic [TAG_BITS-1:0]  res_tag_q, res_tag_d;

  // RAM port
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic [TIME_BITS-1:0] rd_time;
  logic [TYPE_BITS-1:0] rd_type;
  logic [TAG_BITS-1:0]  rd_tag;
  cmp_res_t             cmp_res;

  logic                 in_acc;
  kind_e                in_kind;
  logic [CNT_W-1:0]     idx_inc;      // idx + 1
  logic                 last_scan;    // idx is the last occupied entry
  logic                 scan_hit;
  logic                 full;
  logic                 empty;
  logic [ADDR_W-1:0]    idx_dec;
  logic [ADDR_W-1:0]    idx_nxt;
  logic                 dn_last;      // entry just moved down closes the gap

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_kind = kind_e'(s_axis_tuser);
  assign full    = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_q == '0);

  assign idx_inc   = CNT_W'(idx_q) + CNT_W'(1);
  assign last_scan = (idx_inc == cnt_q);
  assign idx_dec   = idx_q - ADDR_W'(1);
  assign idx_nxt   = idx_q + ADDR_W'(1);
  assign dn_last   = ((idx_inc + CNT_W'(1)) == cnt_q);

  assign {rd_tag, rd_type, rd_time} = ram_rdata;

  etpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  etpq_cmp #(
    .TIME_BITS (TIME_BITS),
    .TYPE_BITS (TYPE_BITS)
  ) u_cmp (
    .slot_time_i (rd_time),
    .slot_type_i (rd_type),
    .key_time_i  (key_time_q),
    .key_type_i  (key_type_q),
    .res_o       (cmp_res)
  );

  // insert stops at the first later time; remove at a type match; pop at the head
  always_comb begin
    case (kind_q)
      KIND_INSERT: scan_hit = !cmp_res.time_le;
      KIND_REMOVE: scan_hit = cmp_res.type_eq;
      default:     scan_hit = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            KIND_INSERT: begin
              if (full)       state_d = S_RESP;
              else if (empty) state_d = S_INS_WR;
              else            state_d = S_SCAN_RD;
            end
            KIND_REMOVE, KIND_POP: begin
              if (empty) state_d = S_RESP;
              else       state_d = S_SCAN_RD;
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_SCAN_RD: state_d = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (scan_hit) begin
          if (kind_q == KIND_INSERT) state_d = S_UP_RD;
          else if (last_scan)        state_d = S_RESP;
          else                       state_d = S_DN_RD;
        end else if (last_scan) begin
          if (kind_q == KIND_INSERT) state_d = S_INS_WR;
          else                       state_d = S_RESP;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_UP_RD: state_d = S_UP_WR;
      S_UP_WR: begin
        if (idx_dec == pos_q) state_d = S_INS_WR;
        else                  state_d = S_UP_RD;
      end
      S_DN_RD: state_d = S_DN_WR;
      S_DN_WR: begin
        if (dn_last) state_d = S_RESP;
        else         state_d = S_DN_RD;
      end
      S_INS_WR: state_d = S_RESP;
      S_RESP: begin
        if (m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs: handshake and RAM port
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx_q;
    ram_wdata     = ram_rdata;
    ram_raddr     = idx_q;
    case (state_q)
      S_IDLE:    s_axis_tready = 1'b1;
      S_UP_RD:   ram_raddr = idx_dec;
      S_DN_RD:   ram_raddr = idx_nxt;
      S_UP_WR,
      S_DN_WR:   ram_we = 1'b1;
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = {key_tag_q, key_type_q, key_time_q};
      end
      S_RESP:    m_axis_tvalid = 1'b1;
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    kind_d     = kind_q;
    key_time_d = key_time_q;
    key_type_d = key_type_q;
    key_tag_d  = key_tag_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    now_d      = now_q;
    status_d   = status_q;
    res_time_d = res_time_q;
    res_type_d = res_type_q;
    res_tag_d  = res_tag_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          kind_d     = in_kind;
          key_time_d = s_axis_tdata[TIME_BITS-1:0];
          key_type_d = s_axis_tdata[TIME_BITS +: TYPE_BITS];
          key_tag_d  = s_axis_tdata[TIME_BITS+TYPE_BITS +: TAG_BITS];
          idx_d      = '0;
          pos_d      = '0;
          res_time_d = '0;
          res_type_d = '0;
          res_tag_d  = '0;
          status_d   = ST_OK;
          case (in_kind)
            KIND_INSERT:           if (full)  status_d = ST_FULL;
            KIND_REMOVE, KIND_POP: if (empty) status_d = ST_EMPTY;
            default: ;
          endcase
        end
      end
      S_SCAN_CMP: begin
        if (scan_hit) begin
          pos_d = idx_q;
          if (kind_q == KIND_INSERT) begin
            idx_d = cnt_q[ADDR_W-1:0];  // queue not full, so count fits
          end else begin
            res_time_d = rd_time;
            res_type_d = rd_type;
            res_tag_d  = rd_tag;
            if (kind_q == KIND_POP) now_d = rd_time;
            if (last_scan)          cnt_d = cnt_q - CNT_W'(1);
          end
        end else if (last_scan) begin
          if (kind_q == KIND_INSERT) pos_d    = cnt_q[ADDR_W-1:0];
          else                       status_d = ST_NOT_FOUND;
        end else begin
          idx_d = idx_nxt;
        end
      end
      S_UP_WR:  idx_d = idx_dec;
      S_DN_WR: begin
        idx_d = idx_nxt;
        if (dn_last) cnt_d = cnt_q - CNT_W'(1);
      end
      S_INS_WR: cnt_d = cnt_q + CNT_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      now_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      now_q   <= now_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    key_time_q <= key_time_d;
    key_type_q <= key_type_d;
    key_tag_q  <= key_tag_d;
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    status_q   <= status_d;
    res_time_q <= res_time_d;
    res_type_q <= res_type_d;
    res_tag_q  <= res_tag_d;
  end

  // result item; clock and count are final by the time the result shows
  always_comb begin
    m_axis_tdata            = '0;
    m_axis_tdata[OUT_W-1:0] = {cnt_q, now_q, res_tag_q, res_type_q, res_time_q};
  end

  assign m_axis_tuser = status_q;

`ifndef ASSERT_OFF
  // occupancy never passes the depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // the block never takes a request while a result is pending
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("request accepted while result pending");

  // writing the new entry grows the queue by exactly one
  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INS_WR |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("insert did not grow queue by one");

  // full is only reported for a full queue
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status_q == ST_FULL) |-> cnt_q == CNT_W'(QUEUE_DEPTH))
    else $error("full reported on non-full queue");
`endif

endmodule

// ===== tb/tb_event_time_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_event_time_priority_queue
// Self-checking bench for the event time priority queue: a cycle-free model
// of the sorted queue predicts every result item, and a scoreboard compares
// each result field by field while both stream sides idle and stall at
// random.
// ----------------------------------------------------------------------------
module tb_event_time_priority_queue;
  import etpq_pkg::*;

  localparam int          Depth      = 16;
  localparam int          InDw       = 48;   // 32 + 4 + 8 bits, byte padded
  localparam int          OutDw      = 88;   // 32 + 4 + 8 + 32 + 5 bits, byte padded
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int          HoldCycles = 400;  // long receiver hold-off
  localparam int          PhaseItems = 575;
  localparam int          TailCycles = 64;

  // one result item, as the block packs it
  typedef struct packed {
    status_e     status;
    logic [31:0] out_time;
    logic [3:0]  out_type;
    logic [7:0]  out_tag;
    logic [31:0] now_time;
    logic [4:0]  occupancy;
  } result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own sorted copy of the queue and the sim clock,
  // works out the result of each accepted request and checks results in order.
  // --------------------------------------------------------------------------
  class event_queue_scoreboard;
    logic [31:0] slot_time [Depth];
    logic [3:0]  slot_type [Depth];
    logic [7:0]  slot_tag  [Depth];
    int          fill;
    logic [31:0] clock;
    result_t     pending_results[$];
    int          errors;
    int          n_items, n_insert, n_remove, n_pop, n_nop;
    int          n_full, n_empty, n_missing;

    function new();
      fill  = 0;
      clock = '0;
    endfunction

    // queue update for one accepted request item
    function void predict_request(kind_e kind, logic [31:0] t, logic [3:0] ty,
                                  logic [7:0] tg);
      result_t r;
      int      pos;
      int      i;
      r        = '0;
      r.status = ST_OK;
      n_items++;
      case (kind)
        KIND_INSERT: begin
          n_insert++;
          if (fill == Depth) begin
            r.status = ST_FULL;
            n_full++;
          end else begin
            // goes behind every entry with time <= t, so ties stay FIFO
            pos = 0;
            while (pos < fill && slot_time[pos] <= t) pos++;
            for (i = fill; i > pos; i--) begin
              slot_time[i] = slot_time[i-1];
              slot_type[i] = slot_type[i-1];
              slot_tag[i]  = slot_tag[i-1];
            end
            slot_time[pos] = t;
            slot_type[pos] = ty;
            slot_tag[pos]  = tg;
            fill++;
          end
        end
        KIND_REMOVE, KIND_POP: begin
          if (kind == KIND_POP) n_pop++;
          else n_remove++;
          if (fill == 0) begin
            r.status = ST_EMPTY;
            n_empty++;
          end else begin
            pos = 0;
            if (kind == KIND_REMOVE)
              while (pos < fill && slot_type[pos] != ty) pos++;
            if (pos == fill) begin
              r.status = ST_NOT_FOUND;
              n_missing++;
            end else begin
              r.out_time = slot_time[pos];
              r.out_type = slot_type[pos];
              r.out_tag  = slot_tag[pos];
              // only a pop moves the clock; remove leaves it alone
              if (kind == KIND_POP) clock = slot_time[pos];
              for (i = pos; i + 1 < fill; i++) begin
                slot_time[i] = slot_time[i+1];
                slot_type[i] = slot_type[i+1];
                slot_tag[i]  = slot_tag[i+1];
              end
              fill--;
            end
          end
        end
        default: n_nop++;
      endcase
      r.now_time  = clock;
      r.occupancy = 5'(fill);
      pending_results.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report("result item with nothing pending", 32'(got.status), '0);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          report("status", 32'(got.status), 32'(want.status));
        if (got.out_time !== want.out_time) report("out_time", got.out_time, want.out_time);
        if (got.out_type !== want.out_type)
          report("out_type", 32'(got.out_type), 32'(want.out_type));
        if (got.out_tag !== want.out_tag)
          report("out_tag", 32'(got.out_tag), 32'(want.out_tag));
        if (got.now_time !== want.now_time) report("now_time", got.now_time, want.now_time);
        if (got.occupancy !== want.occupancy)
          report("occupancy", 32'(got.occupancy), 32'(want.occupancy));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block
  // --------------------------------------------------------------------------
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [InDw-1:0]   s_axis_tdata  = '0;
  logic [1:0]        s_axis_tuser  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OutDw-1:0]  m_axis_tdata;
  logic [1:0]        m_axis_tuser;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  event_time_priority_queue u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  event_queue_scoreboard sched_sb = new();

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_rx       = 1'b0;  // forces tready low during the long hold-off
  bit  filling       = 1'b1;  // random mix leans to inserts while set
  int unsigned cycle_count = 0;

  // --------------------------------------------------------------------------
  // Result side: random tready, and every accepted result goes to the checker.
  // Values read right after the edge are the ones the block saw at that edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    m_axis_tready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
  end

  result_t seen;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.status    = status_e'(m_axis_tuser);
      seen.out_time  = m_axis_tdata[31:0];
      seen.out_type  = m_axis_tdata[35:32];
      seen.out_tag   = m_axis_tdata[43:36];
      seen.now_time  = m_axis_tdata[75:44];
      seen.occupancy = m_axis_tdata[80:76];
      sched_sb.check_result(seen);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Offer one item, with random idle cycles ahead of it, and hold it until
  // taken. tvalid stays high into the next item when no idle cycle falls.
  task automatic send_item(kind_e kind, logic [31:0] t, logic [3:0] ty, logic [7:0] tg);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'b0000, tg, ty, t};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sched_sb.predict_request(kind, t, ty, tg);
  endtask

  // stop offering until every pending result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sched_sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Times: mostly close to the sim clock or equal to a queued time so that
  // ties and near-ordering show up, plus the full range and its two ends.
  function automatic logic [31:0] pick_time();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 4) return sched_sb.clock + 32'($urandom_range(63));
    if (sel < 6 && sched_sb.fill > 0)
      return sched_sb.slot_time[$urandom_range(sched_sb.fill - 1)];
    if (sel == 9) return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
    return $urandom();
  endfunction

  // Random request. The mix swings between filling and draining so the queue
  // keeps running up to full and back down to empty.
  task automatic send_random_item();
    int          roll;
    kind_e       kind;
    logic [3:0]  ty;
    if (filling && sched_sb.fill == Depth && $urandom_range(5) == 0) filling = 1'b0;
    else if (!filling && sched_sb.fill == 0 && $urandom_range(2) == 0) filling = 1'b1;
    else if ($urandom_range(59) == 0) filling = !filling;
    roll = $urandom_range(99);
    if (roll < 4) kind = KIND_NOP;
    else if (roll < (filling ? 70 : 25)) kind = KIND_INSERT;
    else if (roll < (filling ? 85 : 60)) kind = KIND_REMOVE;
    else kind = KIND_POP;
    // few types make matches common; remove mostly names a queued type
    ty = ($urandom_range(9) < 6) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
    if (kind == KIND_REMOVE && sched_sb.fill > 0 && $urandom_range(9) < 7)
      ty = sched_sb.slot_type[$urandom_range(sched_sb.fill - 1)];
    send_item(kind, pick_time(), ty, 8'($urandom_range(255)));
  endtask

  task automatic run_phase(int tx_pct, int rx_pct, int n);
    send_idle_pct = tx_pct;
    recv_idle_pct <= rx_pct;
    repeat (n) send_random_item();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty queue, unused kind, extreme fields, FIFO ties,
    // missing type, remove leaves clock, insert behind the clock
    send_item(KIND_POP,    32'h0,         4'd0,  8'd0);
    send_item(KIND_REMOVE, 32'h0,         4'd15, 8'd0);
    send_item(KIND_NOP,    32'hFFFF_FFFF, 4'd15, 8'd255);
    send_item(KIND_INSERT, 32'hFFFF_FFFF, 4'd15, 8'd255);
    send_item(KIND_INSERT, 32'h0,         4'd0,  8'd0);
    send_item(KIND_INSERT, 32'd100,       4'd5,  8'd1);
    send_item(KIND_INSERT, 32'd100,       4'd5,  8'd2);
    send_item(KIND_INSERT, 32'd100,       4'd9,  8'd3);
    send_item(KIND_REMOVE, 32'h0,         4'd7,  8'd0);
    send_item(KIND_REMOVE, 32'h0,         4'd5,  8'd0);
    send_item(KIND_POP,    32'h0,         4'd0,  8'd0);
    send_item(KIND_POP,    32'h0,         4'd0,  8'd0);
    send_item(KIND_NOP,    32'h5555_AAAA, 4'd10, 8'd85);
    send_item(KIND_INSERT, 32'd50,        4'd9,  8'd4);
    send_item(KIND_REMOVE, 32'hFFFF_FFFF, 4'd9,  8'd255);
    send_item(KIND_POP,    32'h0,         4'd0,  8'd0);
    send_item(KIND_POP,    32'h0,         4'd0,  8'd0);
    send_item(KIND_POP,    32'h0,         4'd0,  8'd0);
    send_item(KIND_REMOVE, 32'h0,         4'd0,  8'd0);
    wait_drained();

    // random: sender idles lightly, receiver heavily
    run_phase(21, 57, PhaseItems);
    wait_drained();

    // roles swapped
    run_phase(57, 21, PhaseItems);
    wait_drained();

    // no idling; the receiver holds off for a long stretch at the start so
    // the result register stays full and the block backs up its input
    fork
      begin
        hold_rx <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_rx <= 1'b0;
      end
    join_none
    run_phase(0, 0, PhaseItems);

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (sched_sb.pending_results.size() != 0)
      sched_sb.report("results still pending", sched_sb.pending_results.size(), '0);

    $display("Ran %0d requests: %0d inserts (%0d refused as full), %0d removes "
             , sched_sb.n_items, sched_sb.n_insert, sched_sb.n_full, sched_sb.n_remove);
    $display("(%0d type misses), %0d pops, %0d on an empty queue, %0d unused-kind items",
             sched_sb.n_missing, sched_sb.n_pop, sched_sb.n_empty, sched_sb.n_nop);
    if (sched_sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
